>>> rtl/tost_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tost_pkg;

	localparam int ID_COUNT = 1024;
	localparam int ID_W     = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int LANES    = 6;

	localparam logic [16:0] WEIGHT_RESET = 17'd6554;
	localparam logic [16:0] WEIGHT_FULL  = 17'd65536;
	localparam logic [31:0] AGE_RESET    = 32'd1000;
	localparam logic [10:0] EVICT_MAX    = 11'd2047;

	// configuration register indexes
	localparam logic REG_SMOOTHING_WEIGHT = 1'b0;
	localparam logic REG_AGE_LIMIT_MS     = 1'b1;

	// request kinds
	localparam logic REQ_OBSERVE = 1'b0;
	localparam logic REQ_SWEEP   = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [9:0]         marker_id;
		logic [31:0]        now_ms;
		logic signed [31:0] pos_x_in;
		logic signed [31:0] pos_y_in;
		logic signed [31:0] pos_z_in;
		logic signed [31:0] rot_x_in;
		logic signed [31:0] rot_y_in;
		logic signed [31:0] rot_z_in;
		logic [21:0]        corner_sum_x;
		logic [21:0]        corner_sum_y;
	} tost_req_t;

	typedef struct packed {
		logic               result_kind;
		logic [9:0]         marker_id_out;
		logic signed [31:0] pos_x_out;
		logic signed [31:0] pos_y_out;
		logic signed [31:0] pos_z_out;
		logic signed [31:0] rot_x_out;
		logic signed [31:0] rot_y_out;
		logic signed [31:0] rot_z_out;
		logic [15:0]        pixel_x;
		logic [15:0]        pixel_y;
		logic               was_tracked;
		logic [10:0]        evicted_count;
	} tost_res_t;

	// controller to datapath
	typedef struct packed {
		logic            rd_req;     // read the table at the incoming id
		logic            capture;    // latch the incoming request
		logic            obs_mul;    // blend stage one: differences times weight
		logic            obs_wr;     // blend stage two: round, store, emit
		logic            clr_wr;     // clear pass write of a live bit
		logic            sweep_rd;   // read one entry for the age check
		logic            sweep_done; // emit the sweep result
		logic [ID_W-1:0] addr;
	} tost_cmd_t;

endpackage

`default_nettype wire

>>> rtl/tracked_object_smoothing_table.sv
// Channel   Signals                                  Beat
// request   start, busy, req                         start & !busy
// result    done, result                             every cycle done is high
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
// Observation: the accept is followed by the blend stages OBS_MUL and OBS_WR; the result
// appears in the cycle after the table write, set by the registered table read and the two blend stages.
// Sweep: every table entry is checked, one entry per cycle, before the sweep result.
// After reset the live bits are cleared, one per cycle: busy is high until
// the clear pass ends. Config writes are taken at any time.
// Results are shown for one cycle only; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module tracked_object_smoothing_table
	import tost_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire tost_req_t   req,
	output logic             done,
	output tost_res_t        result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	tost_cmd_t cmd;

	assign cfg_ready = 1'b1;

	tost_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.busy     (busy),
		.cmd      (cmd)
	);

	tost_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire

>>> rtl/tost_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tost_ctrl
	import tost_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire logic  req_type,
	output logic       busy,
	output tost_cmd_t  cmd
);

	localparam logic [2:0] S_CLEAR     = 3'd0;
	localparam logic [2:0] S_IDLE      = 3'd1;
	localparam logic [2:0] S_OBS_MUL   = 3'd2;
	localparam logic [2:0] S_OBS_WR    = 3'd3;
	localparam logic [2:0] S_SWEEP     = 3'd4;
	localparam logic [2:0] S_SWEEP_END = 3'd5;

	localparam logic [ID_W-1:0] LAST_ID = ID_W'(ID_COUNT - 1);

	logic [2:0]      state_q, state_d;
	logic [ID_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		busy           = 1'b1;
		cmd            = '0;
		cmd.addr       = cnt_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == LAST_ID) begin
					cnt_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy       = 1'b0;
				cmd.rd_req = 1'b1;
				if (start) begin
					cmd.capture = 1'b1;
					cnt_d       = '0;
					state_d     = (req_type == REQ_SWEEP) ? S_SWEEP : S_OBS_MUL;
				end
			end
			S_OBS_MUL: begin
				cmd.obs_mul = 1'b1;
				state_d     = S_OBS_WR;
			end
			S_OBS_WR: begin
				cmd.obs_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == LAST_ID) begin
					cnt_d   = '0;
					state_d = S_SWEEP_END;
				end
			end
			S_SWEEP_END: begin
				// last entry is checked in this cycle
				cmd.sweep_done = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/tost_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tost_datapath
	import tost_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire tost_cmd_t cmd,
	input  wire tost_req_t req,
	input  wire logic  cfg_wr,
	input  wire logic  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic       done,
	output tost_res_t  result
);

	localparam int DW = 32 * LANES;

	// table storage
	logic            live_mem [ID_COUNT];
	logic [31:0]     time_mem [ID_COUNT];
	logic [DW-1:0]   data_mem [ID_COUNT];

	logic            live_rd;
	logic [31:0]     time_rd;
	logic [DW-1:0]   data_rd;

	logic [16:0]     weight_q;
	logic [31:0]     age_limit_q;

	tost_req_t       req_q;
	logic            id_ok_q;
	logic [ID_W-1:0] id_addr_q;

	logic [ID_W-1:0] rd_addr;

	logic            live_we;
	logic [ID_W-1:0] live_waddr;
	logic            live_wdata;
	logic            data_we;

	logic [16:0]     w_eff;
	logic signed [31:0] new_v [LANES];
	logic signed [31:0] old_v [LANES];
	logic signed [31:0] old_s1 [LANES];
	logic signed [50:0] prod_s1 [LANES];
	logic signed [31:0] blend_v [LANES];
	logic signed [31:0] out_v [LANES];
	logic signed [50:0] rounded [LANES];
	logic [DW-1:0]   data_wdata;
	logic            tracked_s1;

	logic            chk_v_s1;
	logic [ID_W-1:0] chk_addr_s1;
	logic            evict_now;
	logic [10:0]     evict_q;
	logic [10:0]     evict_next;

	tost_res_t       res_q;
	logic            done_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= WEIGHT_RESET;
			age_limit_q <= AGE_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_SMOOTHING_WEIGHT: weight_q    <= cfg_data[16:0];
				REG_AGE_LIMIT_MS:     age_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = (weight_q > WEIGHT_FULL) ? WEIGHT_FULL : weight_q;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req;
			id_ok_q   <= (32'(req.marker_id) < ID_COUNT);
			id_addr_q <= ID_W'(req.marker_id);
		end
	end

	assign rd_addr = cmd.rd_req ? ID_W'(req.marker_id) : cmd.addr;

	// sweep check stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_v_s1 <= 1'b0;
		end else begin
			chk_v_s1 <= cmd.sweep_rd;
		end
	end

	always_ff @(posedge clk) begin
		chk_addr_s1 <= cmd.addr;
	end

	assign evict_now  = chk_v_s1 && live_rd && ((req_q.now_ms - time_rd) > age_limit_q);
	assign evict_next = (evict_now && (evict_q != EVICT_MAX)) ? evict_q + 11'd1 : evict_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			evict_q <= '0;
		end else begin
			evict_q <= evict_next;
		end
	end

	// live bit write port: clear pass, eviction, store
	always_comb begin
		live_we    = 1'b0;
		live_waddr = id_addr_q;
		live_wdata = 1'b1;
		if (cmd.clr_wr) begin
			live_we    = 1'b1;
			live_waddr = cmd.addr;
			live_wdata = 1'b0;
		end else if (evict_now) begin
			live_we    = 1'b1;
			live_waddr = chk_addr_s1;
			live_wdata = 1'b0;
		end else if (cmd.obs_wr && id_ok_q) begin
			live_we = 1'b1;
		end
	end

	assign data_we = cmd.obs_wr && id_ok_q;

	always_ff @(posedge clk) begin
		if (live_we) begin
			live_mem[live_waddr] <= live_wdata;
		end
		live_rd <= live_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			time_mem[id_addr_q] <= req_q.now_ms;
			data_mem[id_addr_q] <= data_wdata;
		end
		time_rd <= time_mem[rd_addr];
		data_rd <= data_mem[rd_addr];
	end

	// blend: old + round((new - old) * w / 65536)
	assign new_v[0] = req_q.pos_x_in;
	assign new_v[1] = req_q.pos_y_in;
	assign new_v[2] = req_q.pos_z_in;
	assign new_v[3] = req_q.rot_x_in;
	assign new_v[4] = req_q.rot_y_in;
	assign new_v[5] = req_q.rot_z_in;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			old_v[k]   = data_rd[32*k +: 32];
			rounded[k] = (prod_s1[k] + 51'sd32768) >>> 16;
			blend_v[k] = old_s1[k] + rounded[k][31:0];
			out_v[k]   = tracked_s1 ? blend_v[k] : new_v[k];
			data_wdata[32*k +: 32] = out_v[k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.obs_mul) begin
			tracked_s1 <= id_ok_q && live_rd;
			for (int k = 0; k < LANES; k++) begin
				old_s1[k]  <= old_v[k];
				prod_s1[k] <= 51'(($signed({new_v[k][31], new_v[k]})
					- $signed({old_v[k][31], old_v[k]})) * $signed({1'b0, w_eff}));
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.obs_wr || cmd.sweep_done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.obs_wr) begin
			res_q.result_kind   <= REQ_OBSERVE;
			res_q.marker_id_out <= req_q.marker_id;
			res_q.pos_x_out     <= out_v[0];
			res_q.pos_y_out     <= out_v[1];
			res_q.pos_z_out     <= out_v[2];
			res_q.rot_x_out     <= out_v[3];
			res_q.rot_y_out     <= out_v[4];
			res_q.rot_z_out     <= out_v[5];
			// a 22-bit sum over 64 always fits 16 bits
			res_q.pixel_x       <= req_q.corner_sum_x[21:6];
			res_q.pixel_y       <= req_q.corner_sum_y[21:6];
			res_q.was_tracked   <= tracked_s1;
			res_q.evicted_count <= '0;
		end else if (cmd.sweep_done) begin
			res_q.result_kind   <= REQ_SWEEP;
			res_q.marker_id_out <= '0;
			res_q.pos_x_out     <= '0;
			res_q.pos_y_out     <= '0;
			res_q.pos_z_out     <= '0;
			res_q.rot_x_out     <= '0;
			res_q.rot_y_out     <= '0;
			res_q.rot_z_out     <= '0;
			res_q.pixel_x       <= '0;
			res_q.pixel_y       <= '0;
			res_q.was_tracked   <= 1'b0;
			res_q.evicted_count <= evict_next;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire
